>>> hw/rtl/keypad_matrix_scan_irq_defines.svh
// Assertion macros used by the keypad scanner checker.
`ifndef KEYPAD_MATRIX_SCAN_IRQ_DEFINES_SVH
`define KEYPAD_MATRIX_SCAN_IRQ_DEFINES_SVH

// Property checked on every clock outside reset.
`define KMSI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("keypad scanner check failed");

// Property checked on every clock, reset included.
`define KMSI_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("keypad scanner check failed");

`endif

>>> hw/rtl/kmsi_pkg.sv
// Types and constants of the keypad matrix scanner.
`timescale 1ns / 1ps
package kmsi_pkg;

  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_SCAN   = 2'd1,
    OP_TICK   = 2'd2,
    OP_STATUS = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  key_index;
    logic        key_pressed;
    logic [15:0] write_value;
    logic [15:0] write_mask;
  } in_word_t;

  typedef struct packed {
    logic [7:0] sense_value;
    logic       irq_request;
    logic [7:0] status_read;
  } out_word_t;

  typedef struct packed {
    logic       en;
    logic [5:0] index;
    logic       pressed;
  } key_upd_t;

  localparam int          ROW_STRIDE    = 8;
  localparam int          IRQ_EN_BIT    = 6;
  localparam logic [7:0]  SENSE_IDLE    = 8'hFF;
  localparam logic [7:0]  STATUS_KEYPAD = 8'd2;
  localparam logic [7:0]  STATUS_NONE   = 8'd0;

endpackage

>>> hw/rtl/kmsi_in_stage.sv
// Input register stage of the keypad scanner.
`timescale 1ns / 1ps
module kmsi_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  kmsi_pkg::in_word_t in_word,
  input  logic               adv,
  output logic               proc_valid,
  output kmsi_pkg::in_word_t proc_word
);

  logic               held;
  kmsi_pkg::in_word_t word;

  // free slot, or the held word moves on this cycle
  assign in_ready   = !held || adv;
  assign proc_valid = held;
  assign proc_word  = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= in_word;
    end
  end

endmodule

>>> hw/rtl/kmsi_key_matrix.sv
// Key state array and sense byte formation.
`timescale 1ns / 1ps
module kmsi_key_matrix #(
  parameter int SCAN_ROWS  = 6,
  parameter int SENSE_COLS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  kmsi_pkg::key_upd_t key_upd,
  input  logic [7:0]         scan_reg,
  output logic [7:0]         sense
);

  logic [SCAN_ROWS-1:0][SENSE_COLS-1:0] key_down;
  logic [SENSE_COLS-1:0]                col_pull;

  genvar r, c;
  generate
    for (r = 0; r < SCAN_ROWS; r++) begin : g_row
      for (c = 0; c < SENSE_COLS; c++) begin : g_col
        // keys outside the matrix match no cell and are dropped
        always_ff @(posedge clk) begin
          if (rst) begin
            key_down[r][c] <= 1'b0;
          end else if (key_upd.en &&
                       key_upd.index == 6'(r * kmsi_pkg::ROW_STRIDE + c)) begin
            key_down[r][c] <= key_upd.pressed;
          end
        end
      end
    end

    for (c = 0; c < SENSE_COLS; c++) begin : g_sense
      logic [SCAN_ROWS-1:0] hit;
      for (r = 0; r < SCAN_ROWS; r++) begin : g_hit
        assign hit[r] = !scan_reg[r] && key_down[r][c];
      end
      assign col_pull[c] = |hit;
    end
  endgenerate

  // active low columns; columns beyond the matrix stay high
  always_comb begin
    sense = kmsi_pkg::SENSE_IDLE;
    sense[SENSE_COLS-1:0] = ~col_pull;
  end

endmodule

>>> hw/rtl/kmsi_irq_ctrl.sv
// Scan register, interrupt logic and result register.
`timescale 1ns / 1ps
module kmsi_irq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                proc_valid,
  input  kmsi_pkg::in_word_t  proc_word,
  input  logic [7:0]          sense,
  output logic [7:0]          scan_reg,
  output logic                adv,
  output logic                out_valid,
  input  logic                out_ready,
  output kmsi_pkg::out_word_t out_word
);

  logic       fire;
  logic [7:0] scan_reg_next;
  logic [7:0] last_sense;
  logic [7:0] last_sense_next;
  logic       irq_flag;
  logic       irq_flag_next;
  logic [7:0] status_next;

  assign adv  = !out_valid || out_ready;
  assign fire = proc_valid && adv;

  always_comb begin
    scan_reg_next   = scan_reg;
    last_sense_next = last_sense;
    irq_flag_next   = irq_flag;
    status_next     = kmsi_pkg::STATUS_NONE;
    case (proc_word.op)
      kmsi_pkg::OP_KEY: begin
      end
      kmsi_pkg::OP_SCAN: begin
        if (|proc_word.write_mask[15:8]) begin
          scan_reg_next = proc_word.write_value[15:8];
        end
      end
      kmsi_pkg::OP_TICK: begin
        if (!scan_reg[kmsi_pkg::IRQ_EN_BIT]) begin
          irq_flag_next = 1'b0;
        end else if (last_sense == kmsi_pkg::SENSE_IDLE &&
                     sense != kmsi_pkg::SENSE_IDLE) begin
          irq_flag_next = 1'b1;
        end
        last_sense_next = sense;
      end
      kmsi_pkg::OP_STATUS: begin
        status_next = irq_flag ? kmsi_pkg::STATUS_KEYPAD : kmsi_pkg::STATUS_NONE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_reg   <= 8'd0;
      last_sense <= kmsi_pkg::SENSE_IDLE;
      irq_flag   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (fire) begin
        scan_reg   <= scan_reg_next;
        last_sense <= last_sense_next;
        irq_flag   <= irq_flag_next;
      end
      if (adv) begin
        out_valid <= proc_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word.sense_value <= last_sense_next;
      out_word.irq_request <= irq_flag_next;
      out_word.status_read <= status_next;
    end
  end

endmodule

>>> hw/rtl/keypad_matrix_scan_irq.sv
// Keypad matrix scanner with interrupt: top level.
`timescale 1ns / 1ps
// Takes one word per cycle while the output is not stalled, and returns
// exactly one result word for each. A word is registered at the input,
// handled from the input register (key update, scan register write, tick or
// status read) and its result registered at the output. The key array, scan
// register, last sense byte and interrupt flag update in the cycle the word
// leaves the input register, so every word sees the state left by the word
// before it. A stalled output backs up through the input register to
// in_ready.
module keypad_matrix_scan_irq #(
  parameter int SCAN_ROWS  = 6,
  parameter int SENSE_COLS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  kmsi_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output kmsi_pkg::out_word_t out_word
);

  logic               adv;
  logic               proc_valid;
  kmsi_pkg::in_word_t proc_word;
  kmsi_pkg::key_upd_t key_upd;
  logic [7:0]         scan_reg;
  logic [7:0]         sense;

  assign key_upd.en      = proc_valid && adv && proc_word.op == kmsi_pkg::OP_KEY;
  assign key_upd.index   = proc_word.key_index;
  assign key_upd.pressed = proc_word.key_pressed;

  kmsi_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .adv       (adv),
    .proc_valid(proc_valid),
    .proc_word (proc_word)
  );

  kmsi_key_matrix #(
    .SCAN_ROWS (SCAN_ROWS),
    .SENSE_COLS(SENSE_COLS)
  ) u_matrix (
    .clk     (clk),
    .rst     (rst),
    .key_upd (key_upd),
    .scan_reg(scan_reg),
    .sense   (sense)
  );

  kmsi_irq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .proc_valid(proc_valid),
    .proc_word (proc_word),
    .sense     (sense),
    .scan_reg  (scan_reg),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

>>> hw/rtl/kmsi_checker.sv
// Port-level checks for the keypad scanner, bound to the top level.
`timescale 1ns / 1ps
`include "keypad_matrix_scan_irq_defines.svh"
module kmsi_checker #(
  parameter int SENSE_COLS = 8
) (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input kmsi_pkg::out_word_t out_word
);

  localparam logic [7:0] COL_MASK = 8'((1 << SENSE_COLS) - 1);

  logic status_ok;
  logic cols_ok;

  // status is either empty or the keypad code with the request still up
  assign status_ok = out_word.status_read == kmsi_pkg::STATUS_NONE ||
                     (out_word.status_read == kmsi_pkg::STATUS_KEYPAD &&
                      out_word.irq_request);
  assign cols_ok   = (out_word.sense_value | COL_MASK) == kmsi_pkg::SENSE_IDLE;

  `KMSI_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word))
  `KMSI_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)
  `KMSI_ASSERT(a_status_irq, out_valid |-> status_ok)
  `KMSI_ASSERT(a_unused_cols_high, out_valid |-> cols_ok)

endmodule

bind keypad_matrix_scan_irq kmsi_checker #(
  .SENSE_COLS(SENSE_COLS)
) u_kmsi_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_word (out_word)
);
